// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the star projection block.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold at every clock edge at which the antecedent holds.
`define SVPP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define SVPP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error(msg);

`endif

// ===== hdl/svpp_pkg.sv =====
// Shared types and constants of the star vector pinhole projection block.
// Used by every module of the block; depends on nothing.
package svpp_pkg;

  localparam int unsigned SENSOR_PIXELS_DEF = 1024;

  localparam int unsigned COMP_W    = 16;  // Q1.15 vector and matrix entries
  localparam int unsigned ID_W      = 16;
  localparam int unsigned ROW_W     = 3 * COMP_W;
  localparam int unsigned FOCAL_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = ROW_W;
  localparam int unsigned PROD_W    = 2 * COMP_W;   // one Q2.30 product
  localparam int unsigned ACC_W     = PROD_W + 2;   // sum of three products
  localparam int unsigned MAG_W     = PROD_W;       // |sum| <= 3 * 2^30
  localparam int unsigned Z_W       = PROD_W;       // positive depth
  localparam int unsigned NUM_W     = FOCAL_W + MAG_W;
  localparam int unsigned FRAC_W    = 6;            // Q10.6 pixel fraction
  localparam int unsigned QUOT_W    = 16;           // quotient magnitude bits
  localparam int unsigned REM_W     = Z_W + QUOT_W;
  localparam int unsigned PIX_W     = 16;

  // Edges from the accepting edge to the edge that takes the result.
  localparam int unsigned LATENCY   = QUOT_W + 5;

  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL    = 2'd3;

  localparam logic [ROW_W-1:0]   ROT_ROW0_RST = 48'h0000_0000_7FFF;
  localparam logic [ROW_W-1:0]   ROT_ROW1_RST = 48'h0000_7FFF_0000;
  localparam logic [ROW_W-1:0]   ROT_ROW2_RST = 48'h7FFF_0000_0000;
  localparam logic [FOCAL_W-1:0] FOCAL_RST    = 16'd1024;

  typedef logic [2:0][ROW_W-1:0] rot_mat_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] star_x;
    logic signed [COMP_W-1:0] star_y;
    logic signed [COMP_W-1:0] star_z;
    logic [ID_W-1:0]          star_id;
  } star_in_t;

  typedef struct packed {
    logic              visible;
    logic [PIX_W-1:0]  pixel_u;
    logic [PIX_W-1:0]  pixel_v;
    logic [ID_W-1:0]   out_star_id;
  } star_out_t;

  // Rotated vector handed from the rotation stages to the projection stages.
  typedef struct packed {
    logic                    valid;
    logic [ID_W-1:0]         star_id;
    logic signed [ACC_W-1:0] rot_x;
    logic signed [ACC_W-1:0] rot_y;
    logic signed [ACC_W-1:0] rot_z;
  } proj_req_t;

endpackage

// ===== hdl/svpp_rotate.sv =====
// Two pipeline stages that rotate the star vector by the attitude matrix.
// Depends on svpp_pkg for the payload, matrix and hand-over types.
module svpp_rotate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  svpp_pkg::star_in_t  star_i,
  input  svpp_pkg::rot_mat_t  rot_i,
  output svpp_pkg::proj_req_t req_o
);

  logic signed [svpp_pkg::COMP_W-1:0] vec [3];
  logic signed [svpp_pkg::PROD_W-1:0] prod_q [3][3];
  logic                               prod_vld_q;
  logic [svpp_pkg::ID_W-1:0]          prod_id_q;
  logic signed [svpp_pkg::ACC_W-1:0]  acc [3];
  logic                               req_vld_q;
  logic [svpp_pkg::ID_W-1:0]          req_id_q;
  logic signed [svpp_pkg::ACC_W-1:0]  rot_sum_q [3];

  assign vec[0] = star_i.star_x;
  assign vec[1] = star_i.star_y;
  assign vec[2] = star_i.star_z;

  // Stage one: the nine element products, registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_id_q <= star_i.star_id;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[r][c] <=
          svpp_pkg::PROD_W'($signed(rot_i[r][svpp_pkg::COMP_W*c +: svpp_pkg::COMP_W]))
          * svpp_pkg::PROD_W'(vec[c]);
      end
    end
  end

  // Stage two: the three row sums, kept exact.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = svpp_pkg::ACC_W'(prod_q[r][0]) + svpp_pkg::ACC_W'(prod_q[r][1])
             + svpp_pkg::ACC_W'(prod_q[r][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    req_id_q     <= prod_id_q;
    rot_sum_q[0] <= acc[0];
    rot_sum_q[1] <= acc[1];
    rot_sum_q[2] <= acc[2];
  end

  assign req_o = {req_vld_q, req_id_q, rot_sum_q[0], rot_sum_q[1], rot_sum_q[2]};

endmodule

// ===== hdl/svpp_project.sv =====
// Pinhole projection stages: focal scaling, range pre-check, a pipelined
// restoring divider for both coordinates and the final sensor window test.
// Depends on svpp_pkg for widths and the hand-over and result types.
module svpp_project #(
  parameter int unsigned SENSOR_PIXELS = svpp_pkg::SENSOR_PIXELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [svpp_pkg::FOCAL_W-1:0] focal_i,
  input  svpp_pkg::proj_req_t          req_i,
  output logic                         res_valid_o,
  output svpp_pkg::star_out_t          res_o
);

  localparam int unsigned QW = svpp_pkg::QUOT_W;
  localparam int unsigned RW = svpp_pkg::REM_W;
  localparam int unsigned NW = svpp_pkg::NUM_W;
  localparam logic signed [QW:0] HALF = (QW+1)'(SENSOR_PIXELS * 32);

  // Scaling stage.
  logic [svpp_pkg::ACC_W-1:0] abs_x, abs_y;
  logic                       sc_vld_q, sc_front_q, sc_neg_x_q, sc_neg_y_q;
  logic [svpp_pkg::ID_W-1:0]  sc_id_q;
  logic [svpp_pkg::Z_W-1:0]   sc_z_q;
  logic [NW-1:0]              sc_num_x_q, sc_num_y_q;

  assign abs_x = req_i.rot_x[svpp_pkg::ACC_W-1] ? -req_i.rot_x : req_i.rot_x;
  assign abs_y = req_i.rot_y[svpp_pkg::ACC_W-1] ? -req_i.rot_y : req_i.rot_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q <= 1'b0;
    end else begin
      sc_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sc_id_q    <= req_i.star_id;
    sc_front_q <= req_i.rot_z > 0;
    sc_neg_x_q <= req_i.rot_x[svpp_pkg::ACC_W-1];
    sc_neg_y_q <= req_i.rot_y[svpp_pkg::ACC_W-1];
    sc_z_q     <= req_i.rot_z[svpp_pkg::Z_W-1:0];
    sc_num_x_q <= NW'(focal_i) * NW'(abs_x[svpp_pkg::MAG_W-1:0]);
    sc_num_y_q <= NW'(focal_i) * NW'(abs_y[svpp_pkg::MAG_W-1:0]);
  end

  // Divider stage arrays; entry 0 is written by the pre-check stage.
  logic                      dv_vld_q   [QW+1];
  logic [svpp_pkg::ID_W-1:0] dv_id_q    [QW+1];
  logic                      dv_front_q [QW+1];
  logic                      dv_ok_x_q  [QW+1];
  logic                      dv_ok_y_q  [QW+1];
  logic                      dv_neg_x_q [QW+1];
  logic                      dv_neg_y_q [QW+1];
  logic [svpp_pkg::Z_W-1:0]  dv_z_q     [QW+1];
  logic [RW-1:0]             dv_rem_x_q [QW+1];
  logic [RW-1:0]             dv_rem_y_q [QW+1];
  logic [QW-1:0]             dv_quo_x_q [QW+1];
  logic [QW-1:0]             dv_quo_y_q [QW+1];

  // Pre-check: the quotient magnitude fits QW bits only if
  // num * 2^FRAC_W < z * 2^QW; anything larger is off the sensor anyway.
  logic [NW-1:0] z_bound;
  assign z_bound = NW'(sc_z_q) << (QW - svpp_pkg::FRAC_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= sc_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_id_q[0]    <= sc_id_q;
    dv_front_q[0] <= sc_front_q;
    dv_ok_x_q[0]  <= sc_num_x_q < z_bound;
    dv_ok_y_q[0]  <= sc_num_y_q < z_bound;
    dv_neg_x_q[0] <= sc_neg_x_q;
    dv_neg_y_q[0] <= sc_neg_y_q;
    dv_z_q[0]     <= sc_z_q;
    dv_rem_x_q[0] <= RW'(sc_num_x_q << svpp_pkg::FRAC_W);
    dv_rem_y_q[0] <= RW'(sc_num_y_q << svpp_pkg::FRAC_W);
    dv_quo_x_q[0] <= '0;
    dv_quo_y_q[0] <= '0;
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int unsigned BIT = QW - 1 - k;
    logic [RW-1:0] z_sh;
    logic          ge_x, ge_y;

    assign z_sh = RW'(dv_z_q[k]) << BIT;
    assign ge_x = dv_rem_x_q[k] >= z_sh;
    assign ge_y = dv_rem_y_q[k] >= z_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_id_q[k+1]    <= dv_id_q[k];
      dv_front_q[k+1] <= dv_front_q[k];
      dv_ok_x_q[k+1]  <= dv_ok_x_q[k];
      dv_ok_y_q[k+1]  <= dv_ok_y_q[k];
      dv_neg_x_q[k+1] <= dv_neg_x_q[k];
      dv_neg_y_q[k+1] <= dv_neg_y_q[k];
      dv_z_q[k+1]     <= dv_z_q[k];
      dv_rem_x_q[k+1] <= ge_x ? dv_rem_x_q[k] - z_sh : dv_rem_x_q[k];
      dv_rem_y_q[k+1] <= ge_y ? dv_rem_y_q[k] - z_sh : dv_rem_y_q[k];
      dv_quo_x_q[k+1] <= dv_quo_x_q[k] | (QW'(ge_x) << BIT);
      dv_quo_y_q[k+1] <= dv_quo_y_q[k] | (QW'(ge_y) << BIT);
    end
  end

  // Final stage: restore the sign, apply the centre offset, test the window.
  logic signed [QW:0]  q_x, q_y, u_s, v_s;
  logic                vis;
  svpp_pkg::star_out_t res_d, res_q;
  logic                res_vld_q;

  assign q_x = dv_neg_x_q[QW] ? -$signed({1'b0, dv_quo_x_q[QW]})
                              : $signed({1'b0, dv_quo_x_q[QW]});
  assign q_y = dv_neg_y_q[QW] ? -$signed({1'b0, dv_quo_y_q[QW]})
                              : $signed({1'b0, dv_quo_y_q[QW]});
  assign u_s = q_x + HALF;
  assign v_s = q_y + HALF;

  assign vis = dv_front_q[QW] && dv_ok_x_q[QW] && dv_ok_y_q[QW]
            && (q_x >= -HALF) && (q_x < HALF) && (q_y >= -HALF) && (q_y < HALF);

  always_comb begin
    res_d.visible     = vis;
    res_d.pixel_u     = vis ? u_s[svpp_pkg::PIX_W-1:0] : '0;
    res_d.pixel_v     = vis ? v_s[svpp_pkg::PIX_W-1:0] : '0;
    res_d.out_star_id = dv_id_q[QW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= dv_vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/star_vector_pinhole_projection_core.sv =====
// Top level of the star vector pinhole projection block: configuration
// registers and the two pipeline parts. Depends on svpp_pkg, svpp_rotate
// and svpp_project.
//
// A star transaction is taken at every rising edge at which start is high;
// busy is always low, so a new star may follow in every cycle. Each star
// gives exactly one result after passing in order through the two
// rotation stages, a focal scaling stage, a range pre-check stage, sixteen
// restoring divider stages (one quotient bit each, which sets the depth)
// and an output register. The result is shown for a single cycle with
// result_strobe_o high; there is no back-pressure, so the receiver must
// take it then. Results leave in the order the stars arrived. Pixel
// coordinates are Q10.6 and read zero whenever visible is low. Matrix rows
// and the focal length are written through the plain register port and
// take effect for stars accepted after the write; they should only be
// changed while no transaction is in flight.
module star_vector_pinhole_projection_core #(
  parameter int unsigned SENSOR_PIXELS = svpp_pkg::SENSOR_PIXELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  svpp_pkg::star_in_t             star_i,
  input  logic                           cfg_we_i,
  input  logic [svpp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [svpp_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                           result_strobe_o,
  output svpp_pkg::star_out_t            result_o
);

  svpp_pkg::rot_mat_t           rot_q;
  logic [svpp_pkg::FOCAL_W-1:0] focal_q;
  svpp_pkg::proj_req_t          req;
  logic                         accept;

  // The pipeline never stalls, so the block is always ready.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers. Every index of the port names a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= svpp_pkg::ROT_ROW0_RST;
      rot_q[1] <= svpp_pkg::ROT_ROW1_RST;
      rot_q[2] <= svpp_pkg::ROT_ROW2_RST;
      focal_q  <= svpp_pkg::FOCAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        svpp_pkg::CFG_ROT_ROW0: begin
          rot_q[0] <= cfg_data_i;
        end
        svpp_pkg::CFG_ROT_ROW1: begin
          rot_q[1] <= cfg_data_i;
        end
        svpp_pkg::CFG_ROT_ROW2: begin
          rot_q[2] <= cfg_data_i;
        end
        svpp_pkg::CFG_FOCAL: begin
          focal_q <= cfg_data_i[svpp_pkg::FOCAL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The rotation stages register the products straight from the ports at
  // the accepting edge, so no separate input register is needed.
  svpp_rotate u_rotate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .star_i   (star_i),
    .rot_i    (rot_q),
    .req_o    (req)
  );

  // Projection, division and the sensor window test, ending in the output
  // register that drives the result ports.
  svpp_project #(
    .SENSOR_PIXELS (SENSOR_PIXELS)
  ) u_project (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .focal_i     (focal_q),
    .req_i       (req),
    .res_valid_o (result_strobe_o),
    .res_o       (result_o)
  );

endmodule

// ===== hdl/svpp_checker.sv =====
// Port-level checker of the star projection block and its bind statement.
// Depends on svpp_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module svpp_checker #(
  parameter int unsigned SENSOR_PIXELS = svpp_pkg::SENSOR_PIXELS_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input svpp_pkg::star_in_t  star_i,
  input logic                result_strobe_o,
  input svpp_pkg::star_out_t result_o
);

  localparam int unsigned LIMIT = SENSOR_PIXELS * 64;

  // Every result traces back to a transaction a fixed latency earlier.
  `SVPP_ASSERT_IMPLIES(a_result_has_source, clk_i, rst_ni, result_strobe_o, $past(start && !busy, svpp_pkg::LATENCY), "result without a matching input transaction")

  // The identifier travels with its own star through the whole pipeline.
  `SVPP_ASSERT_IMPLIES(a_id_follows, clk_i, rst_ni, result_strobe_o, result_o.out_star_id == $past(star_i.star_id, svpp_pkg::LATENCY), "result identifier does not match its star")

  // Hidden stars report zero coordinates.
  `SVPP_ASSERT_IMPLIES(a_hidden_zero, clk_i, rst_ni, result_strobe_o && !result_o.visible, result_o.pixel_u == '0 && result_o.pixel_v == '0, "hidden star with non-zero coordinates")

  // Visible stars land inside the sensor window.
  `SVPP_ASSERT_IMPLIES(a_visible_on_sensor, clk_i, rst_ni, result_strobe_o && result_o.visible, 32'(result_o.pixel_u) < LIMIT && 32'(result_o.pixel_v) < LIMIT, "visible star outside the sensor")

  // The pipeline has no back-pressure, so the block never reports busy.
  `SVPP_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy, "block reported busy")

endmodule

bind star_vector_pinhole_projection_core svpp_checker #(
  .SENSOR_PIXELS (SENSOR_PIXELS)
) u_svpp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .star_i          (star_i),
  .result_strobe_o (result_strobe_o),
  .result_o        (result_o)
);
